// ===== design/vtd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the vertex triple deduplicator.
// Depends on nothing; every other design file imports it.

package vtd_pkg;

    // Default table size and stored reference width.
    localparam int VTD_TABLE_DEPTH = 256;
    localparam int VTD_REF_BITS    = 20;

    // Fixed widths of the channel fields.
    localparam int VTD_REF_W   = 20;
    localparam int VTD_INDEX_W = 8;

    // One face corner, as it arrives.
    typedef struct packed {
        logic                 starts_mesh;
        logic [VTD_REF_W-1:0] position_ref;
        logic [VTD_REF_W-1:0] texcoord_ref;
        logic [VTD_REF_W-1:0] normal_ref;
    } corner_t;

    // One unified vertex result.
    typedef struct packed {
        logic [VTD_INDEX_W-1:0] unified_index;
        logic                   is_new;
        logic [VTD_REF_W-1:0]   position_slot;
        logic [VTD_REF_W-1:0]   texcoord_slot;
        logic [VTD_REF_W-1:0]   normal_slot;
        logic                   overflow;
    } vertex_t;

    // Control bits that travel with a corner from cell to cell.
    typedef struct packed {
        logic valid;   // a corner occupies this link
        logic clr;     // corner starts a new mesh: empty every cell it passes
        logic done;    // corner already matched or stored
        logic is_new;  // corner was stored by a cell
    } ctl_t;

endpackage

// ===== design/vtd_corner_if.sv =====
`timescale 1ns / 1ps
// Input channel: one face corner per word, valid/ready handshake.
// Depends on vtd_pkg for corner_t.

interface vtd_corner_if import vtd_pkg::*;;

    logic    valid;
    logic    ready;
    corner_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== design/vtd_vertex_if.sv =====
`timescale 1ns / 1ps
// Output channel: one unified vertex result per word, valid/ready handshake.
// Depends on vtd_pkg for vertex_t.

interface vtd_vertex_if import vtd_pkg::*;;

    logic    valid;
    logic    ready;
    vertex_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== design/vtd_cell.sv =====
`timescale 1ns / 1ps
// One table cell: holds one stored triple and its occupancy, checks the
// passing corner against it and hands the corner on. Depends on vtd_pkg.

module vtd_cell import vtd_pkg::*;
#(
    parameter int TABLE_DEPTH = VTD_TABLE_DEPTH,
    parameter int REF_BITS    = VTD_REF_BITS,
    parameter int CELL_INDEX  = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  ctl_t                          ctl_in,
    input  logic [3*REF_BITS-1:0]         key_in,
    input  logic [$clog2(TABLE_DEPTH)-1:0] idx_in,
    output ctl_t                          ctl_out,
    output logic [3*REF_BITS-1:0]         key_out,
    output logic [$clog2(TABLE_DEPTH)-1:0] idx_out
);

    localparam int KEY_BITS = 3 * REF_BITS;
    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

    logic                occ_reg;
    logic                occ_next;
    logic                occ_eff;
    logic                hit;
    logic                claim;
    logic [KEY_BITS-1:0] entry_reg;
    ctl_t                ctl_reg;
    ctl_t                ctl_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [IDX_BITS-1:0] idx_next;

    always_comb
    begin
        // A mesh start empties this cell before the corner looks at it.
        occ_eff  = occ_reg & ~ctl_in.clr;
        hit      = ctl_in.valid & ~ctl_in.done & occ_eff & (entry_reg == key_in);
        claim    = ctl_in.valid & ~ctl_in.done & ~occ_eff;

        occ_next = occ_reg;
        if (ctl_in.valid)
        begin
            occ_next = occ_eff | claim;
        end

        ctl_next = ctl_in;
        idx_next = idx_in;
        if (hit || claim)
        begin
            ctl_next.done = 1'b1;
            idx_next      = MY_IDX;
        end
        if (claim)
        begin
            ctl_next.is_new = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            occ_reg <= occ_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg <= key_in;
            idx_reg <= idx_next;
            if (claim)
            begin
                entry_reg <= key_in;
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign key_out = key_reg;
    assign idx_out = idx_reg;

endmodule

// ===== design/vtd_out_buf.sv =====
`timescale 1ns / 1ps
// Result formatting and two-word output buffer (output register plus skid).
// Depends on vtd_pkg and vtd_vertex_if.

module vtd_out_buf import vtd_pkg::*;
#(
    parameter int TABLE_DEPTH = VTD_TABLE_DEPTH,
    parameter int REF_BITS    = VTD_REF_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctl_t                           ctl_in,
    input  logic [3*REF_BITS-1:0]          key_in,
    input  logic [$clog2(TABLE_DEPTH)-1:0] idx_in,
    output logic                           adv,
    vtd_vertex_if.source                   vertex
);

    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    logic [REF_BITS-1:0] pos_key;
    logic [REF_BITS-1:0] tex_key;
    logic [REF_BITS-1:0] nrm_key;
    vertex_t             res;
    logic                push;
    logic                pop;
    logic                out_valid_reg;
    logic                out_valid_next;
    vertex_t             out_data_reg;
    vertex_t             out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    vertex_t             skid_data_reg;
    vertex_t             skid_data_next;

    assign pos_key = key_in[3*REF_BITS-1 -: REF_BITS];
    assign tex_key = key_in[2*REF_BITS-1 -: REF_BITS];
    assign nrm_key = key_in[REF_BITS-1:0];

    always_comb
    begin
        res          = '0;
        res.is_new   = ctl_in.is_new;
        res.overflow = ~ctl_in.done;
        if (ctl_in.done)
        begin
            res.unified_index = VTD_INDEX_W'(idx_in);
        end
        if (ctl_in.is_new)
        begin
            // Slots are 0-based and wrap within the stored width.
            res.position_slot = VTD_REF_W'(pos_key - REF_ONE);
            res.texcoord_slot = VTD_REF_W'(tex_key - REF_ONE);
            res.normal_slot   = VTD_REF_W'(nrm_key - REF_ONE);
        end
    end

    // The chain advances as long as the skid stage is free.
    assign adv  = ~skid_valid_reg;
    assign push = ctl_in.valid & adv;
    assign pop  = out_valid_reg & vertex.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign vertex.valid = out_valid_reg;
    assign vertex.data  = out_data_reg;

endmodule

// ===== design/vertex_triple_deduplicator.sv =====
`timescale 1ns / 1ps
// Top level of the vertex triple deduplicator: a chain of table cells and
// the output buffer. Depends on vtd_pkg, vtd_corner_if, vtd_vertex_if,
// vtd_cell and vtd_out_buf.
//
//   channel  | dir | word     | fields
//   ---------+-----+----------+-----------------------------------------------
//   corner   | in  | corner_t | starts_mesh, position/texcoord/normal_ref
//   vertex   | out | vertex_t | unified_index, is_new, three slots, overflow
//
// Flow: one corner word is taken per cycle while corner.ready is high; its
// result is registered by every cell in turn, then by the output register.
// Reset: rst_n empties every cell and clears all valid flags; corner.ready is
// low during reset and the first corner may be taken right after release.
// Stalls: a result waiting on vertex.ready lets the chain move one word into a
// skid stage; once that is full, corner.ready drops and the whole chain holds.

module vertex_triple_deduplicator import vtd_pkg::*;
#(
    parameter int TABLE_DEPTH = VTD_TABLE_DEPTH,
    parameter int REF_BITS    = VTD_REF_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    vtd_corner_if.sink   corner,
    vtd_vertex_if.source vertex
);

    localparam int KEY_BITS = 3 * REF_BITS;
    localparam int IDX_BITS = $clog2(TABLE_DEPTH);

    // Links between cells: link k feeds cell k, link TABLE_DEPTH feeds the
    // output buffer.
    ctl_t                link_ctl [0:TABLE_DEPTH];
    logic [KEY_BITS-1:0] link_key [0:TABLE_DEPTH];
    logic [IDX_BITS-1:0] link_idx [0:TABLE_DEPTH];
    logic                adv;

    // Take a corner whenever the chain advances, never while in reset.
    assign corner.ready = adv & rst_n;

    // Feed the head of the chain straight from the channel; the key is the
    // three references cut or extended to the stored width.
    assign link_ctl[0].valid  = corner.valid & adv;
    assign link_ctl[0].clr    = corner.data.starts_mesh;
    assign link_ctl[0].done   = 1'b0;
    assign link_ctl[0].is_new = 1'b0;
    assign link_key[0] = {REF_BITS'(corner.data.position_ref),
                          REF_BITS'(corner.data.texcoord_ref),
                          REF_BITS'(corner.data.normal_ref)};
    assign link_idx[0] = '0;

    // Each cell owns one table slot. Cells fill from the head in order, so a
    // later corner of the same mesh always sees every triple stored by the corners before it.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        vtd_cell
        #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .REF_BITS    (REF_BITS),
            .CELL_INDEX  (g)
        )
        u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (link_ctl[g]),
            .key_in  (link_key[g]),
            .idx_in  (link_idx[g]),
            .ctl_out (link_ctl[g+1]),
            .key_out (link_key[g+1]),
            .idx_out (link_idx[g+1])
        );
    end

    // Format the result (overflow when no cell matched or stored the corner)
    // and hold it for the consumer.
    vtd_out_buf
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .REF_BITS    (REF_BITS)
    )
    u_out_buf
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (link_ctl[TABLE_DEPTH]),
        .key_in (link_key[TABLE_DEPTH]),
        .idx_in (link_idx[TABLE_DEPTH]),
        .adv    (adv),
        .vertex (vertex)
    );

endmodule

// ===== design/vtd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the vertex triple deduplicator, and the bind that
// attaches them to the top level. Depends on vtd_pkg.

module vtd_checker import vtd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    vertex_valid,
    input logic    vertex_ready,
    input vertex_t vertex_data
);

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_ready |=> vertex_valid)
        else $error("vertex word dropped while stalled");

    // A stalled result word does not change.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_ready |=> $stable(vertex_data))
        else $error("vertex word changed while stalled");

    // A stored triple never reports overflow.
    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> !(vertex_data.is_new && vertex_data.overflow))
        else $error("is_new and overflow both set");

    // Without a store, no fetch slots are offered.
    a_slots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_data.is_new |->
            vertex_data.position_slot == '0 && vertex_data.texcoord_slot == '0 &&
            vertex_data.normal_slot == '0)
        else $error("slot fields set on a word that stored nothing");

    // Overflow reports unified index zero.
    a_overflow_index: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_data.overflow |-> vertex_data.unified_index == '0)
        else $error("overflow word with nonzero index");

endmodule

bind vertex_triple_deduplicator vtd_checker u_vtd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_valid (vertex.valid),
    .vertex_ready (vertex.ready),
    .vertex_data  (vertex.data)
);
